>>> sv/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hierarchical timer wheel
// Field widths, mode and status codes, and the packed stream words.
// ----------------------------------------------------------------------------
package htw_pkg;

   localparam int NumTimers = 32;
   localparam int SlotBits  = 8;
   localparam int NumLevels = 4;
   localparam int IdBits    = 5;
   localparam int LvlBits   = 2;
   localparam int PlaceBits = LvlBits + SlotBits;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_ARM    = 3'd1,
      MODE_CANCEL = 3'd2,
      MODE_CHANGE = 3'd3,
      MODE_PERIOD = 3'd4,
      MODE_ONCE   = 3'd5,
      MODE_QUERY  = 3'd6,
      MODE_QUERY7 = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_PENDING  = 3'd2,
      ST_NOT_PEND = 3'd3,
      ST_NOT_PER  = 3'd4
   } status_type;

   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // req tdata: mode, timer_id, interval, one_shot = 40 bits
   typedef struct packed {
      logic        one_shot;
      logic [30:0] interval;
      logic [4:0]  timer_id;
      logic [2:0]  mode;
   } req_data_type;

   // rsp tdata: timer_id_res, status, remaining, period, pending, is_one_shot
   typedef struct packed {
      logic [5:0]  pad;
      logic        is_one_shot;
      logic        pending;
      logic [31:0] period;
      logic [31:0] remaining;
      logic [2:0]  status;
      logic [4:0]  timer_id_res;
   } rsp_data_type;

endpackage

>>> sv/hierarchical_timer_wheel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_unit: hierarchical timing wheel over timer records
// Commands arm, cancel, retime, set period, make one-shot or query; ticks
// advance the wheel and stream out expiries in ascending timer id order.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser        tlast
// req      in   mode,timer_id,interval,one_shot -            -
// rsp      out  id,status,remaining,period,... event_kind   last result
//
// A command runs these steps from its transfer until ready again: remaining time,
// execute, remaining time for the reply, reply, wait for the rsp transfer.
// Filing adds digit search and place write; a change of remaining time also adds
// a remaining-time step. Per advancing level a tick has a slot snapshot, a visit
// per timer record, and per record found a remaining time, an action and maybe
// filing; the emit pass visits records to the last expiry, emits each, then waits.
// Reset is synchronous; no clearing pass. A stalled rsp holds the sequencer.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mode[2:0], timer_id[7:3], interval[38:8], one_shot[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // timer_id_res, status, remaining, period, pending,
                                    // is_one_shot, zero pad
   output logic        rsp_tuser,   // event_kind
   output logic        rsp_tlast
);

   localparam int IB = htw_pkg::IdBits;
   localparam int SB = htw_pkg::SlotBits;
   localparam int LB = htw_pkg::LvlBits;
   localparam int PB = htw_pkg::PlaceBits;
   localparam int NT = htw_pkg::NumTimers;
   localparam int NL = htw_pkg::NumLevels;

   typedef enum logic [3:0] {
      S_IDLE, S_CMD_LEFT, S_CMD_EXEC, S_PLACE_DIG, S_PLACE_WR, S_REPLY_LEFT,
      S_REPLY, S_TICK_LVL, S_SCAN, S_SCAN_LEFT, S_SCAN_ACT, S_EMIT_LEFT,
      S_EMIT, S_WAIT, S_CHG_LEFT
   } state_type;

   // timer records: start/period/place hold undefined data until armed
   logic [63:0]  start_mem  [NT];
   logic [31:0]  period_mem [NT];
   logic [PB-1:0] place_mem [NT];
   logic [NT-1:0] pend_ff, once_ff, fired_ff, member_ff;

   logic [63:0]  tick_ff;
   logic [SB-1:0] pos_ff [NL];

   state_type    state_ff;
   state_type    ret_ff;       // state after placement
   htw_pkg::req_data_type req_ff;
   logic [IB-1:0] idx_ff;
   logic [LB-1:0] lvl_ff;
   logic [31:0]  left_ff;
   logic [2:0]   status_ff;
   logic [LB-1:0] dig_lvl_ff;
   logic [SB-1:0] dig_ff;

   logic         out_valid_ff, out_kind_ff, out_last_ff;
   htw_pkg::rsp_data_type out_data_ff;

   // shared unit: remaining time of record idx_ff
   logic [63:0]  due;
   logic [31:0]  left_calc;
   logic [IB-1:0] cur_id;
   assign cur_id    = idx_ff;
   assign due       = start_mem[cur_id] + {32'd0, period_mem[cur_id]};
   assign left_calc = (due > tick_ff) ? 32'(due - tick_ff) : 32'd0;

   // placement digit search over levels (few narrow steps)
   logic [LB-1:0] pl_lvl;
   logic [SB-1:0] pl_dig;
   always_comb begin
      pl_lvl = '0;
      pl_dig = left_ff[SB-1:0];
      for (int l = 1; l < NL; l++) begin
         if (SB * l < 32) begin
            if ((left_ff >> (SB * l)) != 32'd0) begin
               pl_lvl = LB'(l);
               pl_dig = SB'(left_ff >> (SB * l));
            end
         end
      end
   end

   logic last_emit;
   always_comb begin
      last_emit = 1'b1;
      for (int i = 0; i < NT; i++)
         if (i > int'(idx_ff) && fired_ff[i]) last_emit = 1'b0;
   end

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= '0;
         once_ff      <= '0;
         fired_ff     <= '0;
         member_ff    <= '0;
         tick_ff      <= '0;
         for (int l = 0; l < NL; l++) pos_ff[l] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  req_ff    <= htw_pkg::req_data_type'(req_tdata);
                  idx_ff    <= req_tdata[7:3];
                  status_ff <= htw_pkg::ST_OK;
                  if (htw_pkg::mode_type'(req_tdata[2:0]) == htw_pkg::MODE_TICK) begin
                     tick_ff  <= tick_ff + 64'd1;
                     fired_ff <= '0;
                     lvl_ff   <= '0;
                     state_ff <= S_TICK_LVL;
                  end else begin
                     state_ff <= S_CMD_LEFT;
                  end
               end
            end
            S_CMD_LEFT: begin
               left_ff  <= left_calc;
               state_ff <= S_CMD_EXEC;
            end
            S_CMD_EXEC: begin
               state_ff <= S_REPLY_LEFT;
               unique case (htw_pkg::mode_type'(req_ff.mode))
                  htw_pkg::MODE_ARM: begin
                     if (req_ff.interval == 31'd0) status_ff <= htw_pkg::ST_ZERO;
                     else if (pend_ff[idx_ff]) status_ff <= htw_pkg::ST_PENDING;
                     else begin
                        start_mem[idx_ff]  <= tick_ff;
                        period_mem[idx_ff] <= {1'b0, req_ff.interval};
                        once_ff[idx_ff]    <= req_ff.one_shot;
                        left_ff  <= {1'b0, req_ff.interval};
                        ret_ff   <= S_REPLY_LEFT;
                        state_ff <= S_PLACE_DIG;
                     end
                  end
                  htw_pkg::MODE_CANCEL: begin
                     if (pend_ff[idx_ff]) begin
                        pend_ff[idx_ff]    <= 1'b0;
                        once_ff[idx_ff]    <= 1'b0;
                        start_mem[idx_ff]  <= '0;
                        period_mem[idx_ff] <= '0;
                        place_mem[idx_ff]  <= '0;
                     end else status_ff <= htw_pkg::ST_NOT_PEND;
                  end
                  htw_pkg::MODE_CHANGE: begin
                     if (pend_ff[idx_ff]) begin
                        period_mem[idx_ff] <= period_mem[idx_ff]
                                              + {1'b0, req_ff.interval} - left_ff;
                        // due time follows the wrapped period
                        ret_ff   <= S_REPLY_LEFT;
                        state_ff <= S_CHG_LEFT;
                     end else status_ff <= htw_pkg::ST_NOT_PEND;
                  end
                  htw_pkg::MODE_PERIOD: begin
                     if (once_ff[idx_ff]) status_ff <= htw_pkg::ST_NOT_PER;
                     else period_mem[idx_ff] <= {1'b0, req_ff.interval};
                  end
                  htw_pkg::MODE_ONCE: once_ff[idx_ff] <= 1'b1;
                  default: ;
               endcase
            end
            S_CHG_LEFT: begin
               left_ff  <= left_calc;
               state_ff <= S_PLACE_DIG;
            end
            S_PLACE_DIG: begin
               // left_ff holds the remaining time of idx_ff
               dig_lvl_ff <= pl_lvl;
               dig_ff     <= pl_dig;
               state_ff   <= S_PLACE_WR;
            end
            S_PLACE_WR: begin
               place_mem[idx_ff] <= {dig_lvl_ff, SB'(pos_ff[dig_lvl_ff] + dig_ff)};
               pend_ff[idx_ff]   <= 1'b1;
               state_ff          <= ret_ff;
            end
            S_REPLY_LEFT: begin
               left_ff  <= left_calc;
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               if (!out_valid_ff) begin
                  out_valid_ff             <= 1'b1;
                  out_kind_ff              <= htw_pkg::KIND_REPLY;
                  out_last_ff              <= 1'b1;
                  out_data_ff.pad          <= '0;
                  out_data_ff.timer_id_res <= idx_ff;
                  out_data_ff.status       <= status_ff;
                  out_data_ff.remaining    <= pend_ff[idx_ff] ? left_ff : 32'd0;
                  out_data_ff.period       <= pend_ff[idx_ff] ? period_mem[idx_ff] : 32'd0;
                  out_data_ff.pending      <= pend_ff[idx_ff];
                  out_data_ff.is_one_shot  <= once_ff[idx_ff];
                  state_ff                 <= S_WAIT;
               end
            end
            S_TICK_LVL: begin
               // advance level, snapshot its slot members
               pos_ff[lvl_ff] <= pos_ff[lvl_ff] + SB'(1);
               for (int i = 0; i < NT; i++)
                  member_ff[i] <= pend_ff[i] &&
                     place_mem[i] == {lvl_ff, SB'(pos_ff[lvl_ff] + SB'(1))};
               idx_ff   <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (member_ff[idx_ff]) begin
                  pend_ff[idx_ff] <= 1'b0;
                  state_ff <= S_SCAN_LEFT;
               end else if (idx_ff == IB'(NT - 1)) begin
                  idx_ff <= '0;
                  if (pos_ff[lvl_ff] == '0 && lvl_ff != LB'(NL - 1)) begin
                     lvl_ff   <= lvl_ff + LB'(1);
                     state_ff <= S_TICK_LVL;
                  end else state_ff <= S_EMIT_LEFT;
               end else idx_ff <= idx_ff + IB'(1);
            end
            S_SCAN_LEFT: begin
               left_ff  <= left_calc;
               state_ff <= S_SCAN_ACT;
            end
            S_SCAN_ACT: begin
               member_ff[idx_ff] <= 1'b0;
               ret_ff            <= S_SCAN;
               if (left_ff != 32'd0) state_ff <= S_PLACE_DIG;
               else begin
                  fired_ff[idx_ff] <= 1'b1;
                  if (!once_ff[idx_ff]) begin
                     start_mem[idx_ff] <= tick_ff;
                     left_ff  <= period_mem[idx_ff];
                     state_ff <= S_PLACE_DIG;
                  end else state_ff <= S_SCAN;
               end
            end
            S_EMIT_LEFT: begin
               if (fired_ff[idx_ff]) begin
                  left_ff  <= left_calc;
                  state_ff <= S_EMIT;
               end else if (idx_ff == IB'(NT - 1)) state_ff <= S_WAIT;
               else idx_ff <= idx_ff + IB'(1);
            end
            S_EMIT: begin
               if (!out_valid_ff) begin
                  out_valid_ff             <= 1'b1;
                  out_kind_ff              <= htw_pkg::KIND_EXPIRY;
                  out_last_ff              <= last_emit;
                  out_data_ff.pad          <= '0;
                  out_data_ff.timer_id_res <= idx_ff;
                  out_data_ff.status       <= htw_pkg::ST_OK;
                  out_data_ff.remaining    <= pend_ff[idx_ff] ? left_ff : 32'd0;
                  out_data_ff.period       <= pend_ff[idx_ff] ? period_mem[idx_ff] : 32'd0;
                  out_data_ff.pending      <= pend_ff[idx_ff];
                  out_data_ff.is_one_shot  <= once_ff[idx_ff];
                  fired_ff[idx_ff]         <= 1'b0;
                  if (last_emit) state_ff <= S_WAIT;
                  else begin
                     idx_ff   <= idx_ff + IB'(1);
                     state_ff <= S_EMIT_LEFT;
                  end
               end
            end
            S_WAIT: begin
               if (!out_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("req ready while sequencer busy");
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == htw_pkg::KIND_REPLY |-> rsp_tlast)
      else $error("command reply without last");

endmodule

>>> tb/hierarchical_timer_wheel_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_unit_tb: self-checking bench for the timer wheel
// Walks a table of directed commands, then random bursts of ticks and timer
// commands under random input gaps and output stalls. A local wheel model
// predicts every reply and expiry, and each rsp transfer is compared with it.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_unit_tb;

   localparam int NumRandom = 350;
   localparam int IdleLimit = 20000;
   localparam int HoldCycles = 500;

   localparam int NumTimers = htw_pkg::NumTimers;
   localparam int SlotBits  = htw_pkg::SlotBits;
   localparam int NumLevels = htw_pkg::NumLevels;
   localparam int LvlBits   = htw_pkg::LvlBits;
   localparam int PlaceBits = htw_pkg::PlaceBits;

   typedef struct {
      logic                  kind;
      htw_pkg::rsp_data_type data;
      logic                  last;
   } wheel_event_type;

   typedef struct {
      htw_pkg::mode_type   mode;
      logic [4:0]          id;
      logic [30:0]         ival;
      logic                once;
      logic                typed;
      htw_pkg::status_type status;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   hierarchical_timer_wheel_unit DUT (.*);

   always #5 clock = ~clock;

   // local copy of the wheel
   logic [63:0]          ticks;
   logic [SlotBits-1:0]  lvl_pos [NumLevels];
   logic [63:0]          t_start [NumTimers];
   logic [31:0]          t_period [NumTimers];
   logic [PlaceBits-1:0] t_place [NumTimers];
   logic                 t_pend [NumTimers];
   logic                 t_once [NumTimers];
   logic                 t_fired [NumTimers];

   wheel_event_type due_events[$];
   int  errors = 0;
   int  accepted = 0;
   bit  stim_done = 0;

   function automatic logic [31:0] ticks_left(int id);
      logic [63:0] due;
      due = t_start[id] + {32'd0, t_period[id]};
      return (due > ticks) ? 32'(due - ticks) : 32'd0;
   endfunction

   function automatic void file_timer(int id);
      logic [31:0] left, tmp, digit;
      int lvl;
      left = ticks_left(id);
      digit = 0;
      for (lvl = NumLevels - 1; lvl > 0; lvl--) begin
         tmp = left << (SlotBits * (NumLevels - 1 - lvl));
         digit = tmp >> (SlotBits * (NumLevels - 1));
         if (digit != 0) break;
      end
      if (lvl == 0) digit = left;
      t_place[id] = {LvlBits'(lvl), SlotBits'(lvl_pos[lvl] + digit)};
      t_pend[id] = 1'b1;
   endfunction

   function automatic void scan_slot(int lvl);
      logic [PlaceBits-1:0] want;
      logic member [NumTimers];
      want = {LvlBits'(lvl), lvl_pos[lvl]};
      for (int i = 0; i < NumTimers; i++) member[i] = t_pend[i] && t_place[i] == want;
      for (int i = 0; i < NumTimers; i++) begin
         if (!member[i]) continue;
         t_pend[i] = 1'b0;
         if (ticks_left(i) != 0) begin
            file_timer(i);
            continue;
         end
         t_fired[i] = 1'b1;
         if (!t_once[i]) begin
            t_start[i] = ticks;
            file_timer(i);
         end
      end
   endfunction

   function automatic wheel_event_type timer_view(logic kind, int id,
                                                  htw_pkg::status_type st);
      wheel_event_type ev;
      ev.kind = kind;
      ev.last = 1'b1;
      ev.data = '0;
      ev.data.timer_id_res = 5'(id);
      ev.data.status = st;
      ev.data.pending = t_pend[id];
      ev.data.is_one_shot = t_once[id];
      if (t_pend[id]) begin
         ev.data.remaining = ticks_left(id);
         ev.data.period = t_period[id];
      end
      return ev;
   endfunction

   // advance the local wheel by one accepted request and queue its results
   function automatic void wheel_step(htw_pkg::req_data_type rq);
      int id;
      int n;
      logic [31:0] left;
      htw_pkg::status_type st;
      id = rq.timer_id;
      st = htw_pkg::ST_OK;
      case (htw_pkg::mode_type'(rq.mode))
         htw_pkg::MODE_TICK: begin
            for (int i = 0; i < NumTimers; i++) t_fired[i] = 1'b0;
            ticks++;
            for (int l = 0; l < NumLevels; l++) begin
               lvl_pos[l] = lvl_pos[l] + 1'b1;
               scan_slot(l);
               if (lvl_pos[l] != 0) break;
            end
            n = 0;
            for (int i = 0; i < NumTimers; i++) begin
               if (!t_fired[i]) continue;
               due_events.push_back(timer_view(htw_pkg::KIND_EXPIRY, i, htw_pkg::ST_OK));
               due_events[$].last = 1'b0;
               n++;
            end
            if (n > 0) due_events[$].last = 1'b1;
            return;
         end
         htw_pkg::MODE_ARM: begin
            if (rq.interval == 0) st = htw_pkg::ST_ZERO;
            else if (t_pend[id]) st = htw_pkg::ST_PENDING;
            else begin
               t_start[id] = ticks;
               t_period[id] = {1'b0, rq.interval};
               t_once[id] = rq.one_shot;
               file_timer(id);
            end
         end
         htw_pkg::MODE_CANCEL: begin
            if (t_pend[id]) begin
               t_pend[id] = 0; t_once[id] = 0;
               t_start[id] = 0; t_period[id] = 0; t_place[id] = 0;
            end else st = htw_pkg::ST_NOT_PEND;
         end
         htw_pkg::MODE_CHANGE: begin
            if (t_pend[id]) begin
               left = ticks_left(id);
               t_pend[id] = 1'b0;
               t_period[id] = t_period[id] + {1'b0, rq.interval} - left;
               file_timer(id);
            end else st = htw_pkg::ST_NOT_PEND;
         end
         htw_pkg::MODE_PERIOD: begin
            if (t_once[id]) st = htw_pkg::ST_NOT_PER;
            else t_period[id] = {1'b0, rq.interval};
         end
         htw_pkg::MODE_ONCE: t_once[id] = 1'b1;
         default: ;
      endcase
      due_events.push_back(timer_view(htw_pkg::KIND_REPLY, id, st));
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // receiver and watchdog
   int idle = 0;
   always @(posedge clock) begin
      wheel_event_type       ev;
      htw_pkg::rsp_data_type got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IdleLimit) begin
            $display("hierarchical_timer_wheel_unit_tb: done, errors");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_events.size() == 0) begin
               report_mismatch("unexpected transfer, id", got.timer_id_res, 0);
            end else begin
               ev = due_events.pop_front();
               if (rsp_tuser !== ev.kind) report_mismatch("event_kind", rsp_tuser, ev.kind);
               if (got.timer_id_res !== ev.data.timer_id_res)
                  report_mismatch("timer_id", got.timer_id_res, ev.data.timer_id_res);
               if (got.status !== ev.data.status)
                  report_mismatch("status", got.status, ev.data.status);
               if (got.remaining !== ev.data.remaining)
                  report_mismatch("remaining", got.remaining, ev.data.remaining);
               if (got.period !== ev.data.period)
                  report_mismatch("period", got.period, ev.data.period);
               if (got.pending !== ev.data.pending)
                  report_mismatch("pending", got.pending, ev.data.pending);
               if (got.is_one_shot !== ev.data.is_one_shot)
                  report_mismatch("is_one_shot", got.is_one_shot, ev.data.is_one_shot);
               if (rsp_tlast !== ev.last) report_mismatch("tlast", rsp_tlast, ev.last);
            end
         end
      end
   end

   // stall pattern on rsp, with one long hold while the sender keeps going
   initial begin
      int phase;
      bit held;
      phase = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && accepted >= 120) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         phase = (phase + 1) % 64;
         if (phase < 20) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   function automatic htw_pkg::req_data_type random_request();
      htw_pkg::req_data_type rq;
      int pick;
      rq.timer_id = 5'($urandom_range(0, NumTimers - 1));
      rq.one_shot = 1'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) rq.interval = 31'($urandom_range(1, 40));
      else if (pick < 9) rq.interval = 31'($urandom_range(0, 700));
      else rq.interval = 31'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) rq.mode = htw_pkg::MODE_TICK;
      else if (pick < 72) rq.mode = htw_pkg::MODE_ARM;
      else if (pick < 80) rq.mode = htw_pkg::MODE_CANCEL;
      else if (pick < 86) rq.mode = htw_pkg::MODE_CHANGE;
      else if (pick < 91) rq.mode = htw_pkg::MODE_PERIOD;
      else if (pick < 94) rq.mode = htw_pkg::MODE_ONCE;
      else if (pick < 98) rq.mode = htw_pkg::MODE_QUERY;
      else rq.mode = htw_pkg::MODE_QUERY7;
      return rq;
   endfunction

   step_row_type plan [] = '{
      '{htw_pkg::MODE_QUERY,  5'd0,  31'd0,        1'b0, 1'b1, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd1,  31'd0,        1'b0, 1'b1, htw_pkg::ST_ZERO},
      '{htw_pkg::MODE_CANCEL, 5'd2,  31'd0,        1'b0, 1'b1, htw_pkg::ST_NOT_PEND},
      '{htw_pkg::MODE_CHANGE, 5'd3,  31'd9,        1'b0, 1'b1, htw_pkg::ST_NOT_PEND},
      '{htw_pkg::MODE_ARM,    5'd4,  31'd1,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd4,  31'd5,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_TICK,   5'd0,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_PERIOD, 5'd4,  31'd3,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ONCE,   5'd4,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_PERIOD, 5'd4,  31'd7,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd5,  31'h7fffffff, 1'b1, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd6,  31'd300,      1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_CHANGE, 5'd6,  31'd2,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd7,  31'd1,        1'b1, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_TICK,   5'd0,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_TICK,   5'd0,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_CANCEL, 5'd6,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_QUERY7, 5'd31, 31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_ARM,    5'd31, 31'd256,      1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_QUERY,  5'd31, 31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_CHANGE, 5'd5,  31'h40000000, 1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_CANCEL, 5'd5,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK},
      '{htw_pkg::MODE_CANCEL, 5'd4,  31'd0,        1'b0, 1'b0, htw_pkg::ST_OK}
   };

   // sender: bursts of requests with random gaps
   initial begin
      htw_pkg::req_data_type rq;
      int burst;
      int gap;
      int total;
      wheel_event_type ev;
      ticks = 0;
      for (int l = 0; l < NumLevels; l++) lvl_pos[l] = 0;
      for (int i = 0; i < NumTimers; i++) begin
         t_start[i] = 0; t_period[i] = 0; t_place[i] = 0;
         t_pend[i] = 0; t_once[i] = 0; t_fired[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst = 0;
      total = plan.size() + NumRandom;
      for (int k = 0; k < total; k++) begin
         if (k < plan.size()) begin
            rq.mode = plan[k].mode;
            rq.timer_id = plan[k].id;
            rq.interval = plan[k].ival;
            rq.one_shot = plan[k].once;
         end else rq = random_request();
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst--;
         req_tvalid <= 1'b1;
         req_tdata <= rq;
         do @(posedge clock); while (!req_tready);
         wheel_step(rq);
         // directed rows with a reply readable at a glance
         if (k < plan.size() && plan[k].typed) begin
            ev = '{htw_pkg::KIND_REPLY, '0, 1'b1};
            ev.data.timer_id_res = plan[k].id;
            ev.data.status = plan[k].status;
            due_events[$] = ev;
         end
         accepted++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
      wait (due_events.size() == 0);
      repeat (700) @(posedge clock);
      if (errors == 0) $display("hierarchical_timer_wheel_unit_tb: done, clean");
      else $display("hierarchical_timer_wheel_unit_tb: done, errors");
      $finish;
   end

endmodule
